[sv/pid_positional_incremental_assert.svh]
// ----------------------------------------------------------------------------
// PID controller assertion macros
// Shared property forms for the controller checks.
// ----------------------------------------------------------------------------
`ifndef PID_POSITIONAL_INCREMENTAL_ASSERT_SVH
`define PID_POSITIONAL_INCREMENTAL_ASSERT_SVH

// same-cycle implication
`define PIDPI_ASSERT_IMP(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("pid controller check failed");

// next-cycle implication
`define PIDPI_ASSERT_NXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("pid controller check failed");

`endif

[sv/pidpi_pkg.sv]
// ----------------------------------------------------------------------------
// PID controller package
// Widths, codes and shared types of the controller.
// ----------------------------------------------------------------------------
package pidpi_pkg;

   localparam int FRAC_BITS_DEF = 16;
   localparam int D_FILTER_Q16  = 0;
   localparam int DATA_W        = 32;
   localparam int MUL_A_W       = 35;
   localparam int MUL_B_W       = 32;
   localparam int DIV_NUM_W     = 34;
   localparam int DIV_DEN_W     = 31;
   localparam int CSR_IDX_W     = 4;

   localparam logic [CSR_IDX_W-1:0] CSR_GAIN_P   = 4'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_GAIN_I   = 4'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_GAIN_D   = 4'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_MODE     = 4'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_OUT_LOW  = 4'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_OUT_HIGH = 4'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_ACC_LOW  = 4'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_ACC_HIGH = 4'd7;

   localparam logic OP_STEP  = 1'b0;
   localparam logic OP_CLEAR = 1'b1;
   localparam logic MODE_POS = 1'b0;
   localparam logic MODE_INC = 1'b1;

   typedef enum logic [3:0] {
      ST_IDLE, ST_ERR, ST_TRAP, ST_DIV, ST_FILT, ST_MP, ST_MI, ST_MD,
      ST_SUM, ST_FIN, ST_OUT
   } pidpi_state_type;

   typedef enum logic [1:0] {
      SH_FRAC, SH_TRAP, SH_Q16
   } pidpi_shift_type;

   typedef struct packed {
      logic            start;
      pidpi_shift_type shift;
   } pidpi_mul_ctl_type;

endpackage

[sv/pidpi_mul.sv]
// ----------------------------------------------------------------------------
// PID serial multiplier
// Sign-magnitude shift-add multiply, one multiplier bit per cycle, with a
// truncating right shift of the product toward zero.
// ----------------------------------------------------------------------------
module pidpi_mul
   import pidpi_pkg::*;
#(
   parameter int FRAC_BITS = FRAC_BITS_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  pidpi_mul_ctl_type          ctl,
   input  logic signed [MUL_A_W-1:0]  a_in,
   input  logic signed [MUL_B_W-1:0]  b_in,
   output logic                       done,
   output logic signed [63:0]         result
);

   localparam int PW    = MUL_A_W + MUL_B_W;
   localparam int CNT_W = $clog2(MUL_B_W + 1);
   localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(MUL_B_W - 1);

   logic [MUL_A_W-1:0] ma_ff, ma_in;
   logic [MUL_B_W-1:0] mb_ff, mb_in;
   logic [PW-1:0]      prod_ff, prod_in;
   logic               neg_ff, neg_in;
   pidpi_shift_type    sh_ff, sh_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic               busy_ff, busy_in;
   logic               fin_ff, fin_in;
   logic               done_ff, done_in;
   logic signed [63:0] result_ff, result_in;
   logic [MUL_A_W:0]   sum;
   logic [PW-1:0]      shifted;
   logic [63:0]        mag;

   always_comb begin
      sum = {1'b0, prod_ff[PW-1:MUL_B_W]} + {1'b0, (mb_ff[0] ? ma_ff : '0)};
      case (sh_ff)
         SH_FRAC: shifted = prod_ff >> FRAC_BITS;
         SH_TRAP: shifted = prod_ff >> (FRAC_BITS + 1);
         SH_Q16:  shifted = prod_ff >> 16;
         default: shifted = prod_ff;
      endcase
      mag = shifted[63:0];
   end

   always_comb begin
      ma_in     = ma_ff;
      mb_in     = mb_ff;
      prod_in   = prod_ff;
      neg_in    = neg_ff;
      sh_in     = sh_ff;
      cnt_in    = cnt_ff;
      busy_in   = busy_ff;
      fin_in    = 1'b0;
      done_in   = 1'b0;
      result_in = result_ff;
      if (ctl.start && !busy_ff) begin
         ma_in   = a_in[MUL_A_W-1] ? MUL_A_W'(-a_in) : MUL_A_W'(a_in);
         mb_in   = b_in[MUL_B_W-1] ? MUL_B_W'(-b_in) : MUL_B_W'(b_in);
         neg_in  = a_in[MUL_A_W-1] ^ b_in[MUL_B_W-1];
         sh_in   = ctl.shift;
         prod_in = '0;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         prod_in = {sum, prod_ff[MUL_B_W-1:1]};
         mb_in   = mb_ff >> 1;
         cnt_in  = cnt_ff + 1'b1;
         if (cnt_ff == CNT_LAST) begin
            busy_in = 1'b0;
            fin_in  = 1'b1;
         end
      end
      if (fin_ff) begin
         result_in = neg_ff ? -$signed(mag) : $signed(mag);
         done_in   = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         fin_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         fin_ff  <= fin_in;
         done_ff <= done_in;
      end
      ma_ff     <= ma_in;
      mb_ff     <= mb_in;
      prod_ff   <= prod_in;
      neg_ff    <= neg_in;
      sh_ff     <= sh_in;
      cnt_ff    <= cnt_in;
      result_ff <= result_in;
   end

   assign done   = done_ff;
   assign result = result_ff;

endmodule

[sv/pidpi_div.sv]
// ----------------------------------------------------------------------------
// PID serial divider
// Restoring unsigned divide of a magnitude scaled by the fraction bits,
// one quotient bit per cycle.
// ----------------------------------------------------------------------------
module pidpi_div
   import pidpi_pkg::*;
#(
   parameter int FRAC_BITS = FRAC_BITS_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [DIV_NUM_W-1:0]         num_in,
   input  logic [DIV_DEN_W-1:0]         den_val,
   output logic                         done,
   output logic [DIV_NUM_W+FRAC_BITS-1:0] quot
);

   localparam int QW    = DIV_NUM_W + FRAC_BITS;
   localparam int REM_W = DIV_DEN_W + 1;
   localparam int CNT_W = $clog2(QW + 1);
   localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(QW - 1);

   logic [QW-1:0]        q_ff, q_in;
   logic [REM_W-1:0]     rem_ff, rem_in;
   logic [DIV_DEN_W-1:0] den_ff, den_in;
   logic [CNT_W-1:0]     cnt_ff, cnt_in;
   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [REM_W-1:0]     trial;
   logic                 ge;

   always_comb begin
      trial   = {rem_ff[REM_W-2:0], q_ff[QW-1]};
      ge      = trial >= {1'b0, den_ff};
      q_in    = q_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start && !busy_ff) begin
         q_in    = {num_in, {FRAC_BITS{1'b0}}};
         rem_in  = '0;
         den_in  = den_val;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = ge ? trial - {1'b0, den_ff} : trial;
         q_in   = {q_ff[QW-2:0], ge};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_LAST) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      q_ff   <= q_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
      cnt_ff <= cnt_in;
   end

   assign done = done_ff;
   assign quot = q_ff;

endmodule

[sv/pid_positional_incremental.sv]
// ----------------------------------------------------------------------------
// PID controller, positional or incremental
// Signed fixed-point PID step with a shared serial multiplier and divider.
// ----------------------------------------------------------------------------
//   channel  ports   direction  transfer
//   request  req_*   in         req_valid & req_ready
//   response rsp_*   out        rsp_valid & rsp_ready
//   config   csr_*   in         csr_we, one cycle, no read-back
//
// One item at a time. Each multiply runs on the shared shift-add multiplier.
// A positional step with update at Q16.16 takes about 4 multiplies plus the
// divide, an incremental step up to 3 multiplies, a clear request none.
// Reset needs no clearing pass. A stalled response holds in its register;
// the next request is taken meanwhile.
// ----------------------------------------------------------------------------
module pid_positional_incremental
   import pidpi_pkg::*;
#(
   parameter int FRAC_BITS = FRAC_BITS_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic                        req_op,
   input  logic signed [DATA_W-1:0]    req_target,
   input  logic signed [DATA_W-1:0]    req_feedback,
   input  logic signed [DATA_W-1:0]    req_step_time,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic signed [DATA_W-1:0]    rsp_drive,
   output logic signed [DATA_W-1:0]    rsp_p_part,
   output logic signed [DATA_W-1:0]    rsp_i_part,
   output logic signed [DATA_W-1:0]    rsp_d_part,
   output logic signed [DATA_W-1:0]    rsp_raw_sum,
   output logic                        rsp_fault,
   input  logic                        csr_we,
   input  logic [CSR_IDX_W-1:0]        csr_index,
   input  logic [DATA_W-1:0]           csr_wdata
);

`include "pid_positional_incremental_assert.svh"

   localparam int  QW      = DIV_NUM_W + FRAC_BITS;
   localparam bit  FILT_ON = D_FILTER_Q16 > 0;
   localparam logic signed [MUL_B_W-1:0] FILT_K = MUL_B_W'(65536 - D_FILTER_Q16);
   localparam logic signed [DATA_W-1:0]  S32_MAX = {1'b0, {(DATA_W-1){1'b1}}};
   localparam logic signed [DATA_W-1:0]  S32_MIN = {1'b1, {(DATA_W-1){1'b0}}};

   function automatic logic signed [63:0] clamp64(logic signed [63:0] v,
                                                 logic signed [DATA_W-1:0] lo,
                                                 logic signed [DATA_W-1:0] hi);
      logic signed [63:0] lo64;
      logic signed [63:0] hi64;
      lo64 = 64'(lo);
      hi64 = 64'(hi);
      if (v < lo64) return lo64;
      if (v > hi64) return hi64;
      return v;
   endfunction

   function automatic logic fits32(logic signed [63:0] v);
      return (&v[63:DATA_W-1]) || !(|v[63:DATA_W-1]);
   endfunction

   pidpi_state_type state_ff, state_in;

   logic signed [DATA_W-1:0] gain_p_ff, gain_i_ff, gain_d_ff;
   logic                     mode_ff;
   logic signed [DATA_W-1:0] out_low_ff, out_high_ff, acc_low_ff, acc_high_ff;

   logic                     op_ff;
   logic signed [DATA_W-1:0] tgt_ff, fbk_ff, dt_ff;
   logic signed [DATA_W-1:0] e_ff, le_ff, lle_ff, acc_ff, pd_ff;
   logic                     first_ff;
   logic signed [DATA_W-1:0] accn_ff, deriv_ff;
   logic signed [63:0]       p_ff, i_ff, d_ff;
   logic signed [34:0]       raw_ff;
   logic                     flt_ff;
   logic                     launch_ff;

   logic signed [DATA_W-1:0] res_drive_ff, res_p_ff, res_i_ff, res_d_ff, res_raw_ff;
   logic                     res_fault_ff;
   logic                     rsp_valid_ff;
   logic signed [DATA_W-1:0] rsp_drive_ff, rsp_p_ff, rsp_i_ff, rsp_d_ff, rsp_raw_ff;
   logic                     rsp_fault_ff;

   pidpi_mul_ctl_type        mul_ctl;
   logic signed [MUL_A_W-1:0] mul_a;
   logic signed [MUL_B_W-1:0] mul_b;
   logic                     mul_done;
   logic signed [63:0]       mul_res;
   logic                     mul_state;
   logic                     div_start, div_done;
   logic [QW-1:0]            div_q;

   logic signed [DATA_W:0]   e_w;
   logic                     e_fits, upd_w;
   logic signed [MUL_A_W-1:0] e35, le35, lle35, d2e;
   logic signed [DIV_NUM_W-1:0] de34;
   logic [DIV_NUM_W-1:0]     de_mag;
   logic                     q_hi_zero;
   logic signed [DATA_W-1:0] q_sat;
   logic signed [63:0]       sum_w, raw64, t_w, accf_w, drv_w;
   logic signed [63:0]       acc_hold_w, acc_trap_w, filt_w, rawn_w;
   logic                     fin_fault;
   logic                     accept, out_load;

   // handshake
   assign accept    = req_valid && req_ready;
   assign out_load  = (state_ff == ST_OUT) && (!rsp_valid_ff || rsp_ready);
   assign req_ready = (state_ff == ST_IDLE);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: if (req_valid) state_in = ST_ERR;
         ST_ERR: begin
            if (op_ff == OP_CLEAR || !e_fits) state_in = ST_OUT;
            else if (mode_ff == MODE_POS && upd_w) state_in = ST_TRAP;
            else state_in = ST_MP;
         end
         ST_TRAP: if (mul_done) state_in = ST_DIV;
         ST_DIV:  if (div_done) state_in = FILT_ON ? ST_FILT : ST_MP;
         ST_FILT: if (mul_done) state_in = ST_MP;
         ST_MP:   if (mul_done) state_in = ST_MI;
         ST_MI: begin
            if (mul_done) state_in = (mode_ff == MODE_INC && first_ff) ? ST_SUM : ST_MD;
         end
         ST_MD:   if (mul_done) state_in = ST_SUM;
         ST_SUM:  state_in = ST_FIN;
         ST_FIN:  state_in = ST_OUT;
         ST_OUT:  if (!rsp_valid_ff || rsp_ready) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   // datapath terms
   always_comb begin
      e_w    = DATA_W'(0) + ($signed({tgt_ff[DATA_W-1], tgt_ff}) -
                             $signed({fbk_ff[DATA_W-1], fbk_ff}));
      e_fits = (e_w[DATA_W] == e_w[DATA_W-1]);
      upd_w  = !first_ff && !dt_ff[DATA_W-1] && (dt_ff != '0);
      e35    = MUL_A_W'(e_ff);
      le35   = MUL_A_W'(le_ff);
      lle35  = MUL_A_W'(lle_ff);
      d2e    = e35 - (le35 <<< 1) + lle35;
      de34   = DIV_NUM_W'(e_ff) - DIV_NUM_W'(le_ff);
      de_mag = de34[DIV_NUM_W-1] ? DIV_NUM_W'(-de34) : DIV_NUM_W'(de34);
      q_hi_zero = ((div_q >> (DATA_W-1)) == '0);
      if (de34[DIV_NUM_W-1]) begin
         q_sat = q_hi_zero ? -$signed({1'b0, div_q[DATA_W-2:0]}) : S32_MIN;
      end else begin
         q_sat = q_hi_zero ? $signed({1'b0, div_q[DATA_W-2:0]}) : S32_MAX;
      end
   end

   // multiplier operands
   always_comb begin
      mul_a         = '0;
      mul_b         = '0;
      mul_ctl.shift = SH_FRAC;
      mul_state     = 1'b1;
      case (state_ff)
         ST_TRAP: begin
            mul_a         = e35 + le35;
            mul_b         = dt_ff;
            mul_ctl.shift = SH_TRAP;
         end
         ST_FILT: begin
            mul_a         = MUL_A_W'(deriv_ff) - MUL_A_W'(pd_ff);
            mul_b         = FILT_K;
            mul_ctl.shift = SH_Q16;
         end
         ST_MP: begin
            mul_a = (mode_ff == MODE_INC && !first_ff) ? e35 - le35 : e35;
            mul_b = gain_p_ff;
         end
         ST_MI: begin
            mul_a = (mode_ff == MODE_INC) ? e35 : MUL_A_W'(accn_ff);
            mul_b = gain_i_ff;
         end
         ST_MD: begin
            mul_a = (mode_ff == MODE_INC) ? d2e : MUL_A_W'(deriv_ff);
            mul_b = gain_d_ff;
         end
         default: mul_state = 1'b0;
      endcase
      mul_ctl.start = mul_state && !launch_ff;
      div_start     = (state_ff == ST_DIV) && !launch_ff;
   end

   // final combine
   always_comb begin
      sum_w      = p_ff + i_ff + d_ff;
      acc_hold_w = clamp64(64'(acc_ff), acc_low_ff, acc_high_ff);
      acc_trap_w = clamp64(64'(acc_ff) + mul_res, acc_low_ff, acc_high_ff);
      filt_w     = 64'(pd_ff) + mul_res;
      rawn_w     = (mode_ff == MODE_INC && !first_ff) ? sum_w + 64'(acc_ff) : sum_w;
      raw64  = 64'(raw_ff);
      t_w    = clamp64(clamp64(raw64, acc_low_ff, acc_high_ff), out_low_ff, out_high_ff);
      accf_w = 64'(accn_ff);
      drv_w  = clamp64(raw64, out_low_ff, out_high_ff);
      if (mode_ff == MODE_INC) begin
         if (first_ff) begin
            accf_w = raw64;
         end else begin
            accf_w = t_w;
            drv_w  = clamp64(t_w, out_low_ff, out_high_ff);
         end
      end
      fin_fault = flt_ff || !fits32(accf_w);
   end

   pidpi_mul #(.FRAC_BITS(FRAC_BITS)) u_mul (
      .clock  (clock),
      .reset  (reset),
      .ctl    (mul_ctl),
      .a_in   (mul_a),
      .b_in   (mul_b),
      .done   (mul_done),
      .result (mul_res)
   );

   pidpi_div #(.FRAC_BITS(FRAC_BITS)) u_div (
      .clock   (clock),
      .reset   (reset),
      .start   (div_start),
      .num_in  (de_mag),
      .den_val (dt_ff[DIV_DEN_W-1:0]),
      .done    (div_done),
      .quot    (div_q)
   );

   // control and loop state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         launch_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
         gain_p_ff    <= '0;
         gain_i_ff    <= '0;
         gain_d_ff    <= '0;
         mode_ff      <= MODE_POS;
         out_low_ff   <= S32_MIN;
         out_high_ff  <= S32_MAX;
         acc_low_ff   <= S32_MIN;
         acc_high_ff  <= S32_MAX;
         le_ff        <= '0;
         lle_ff       <= '0;
         acc_ff       <= '0;
         pd_ff        <= '0;
         first_ff     <= 1'b1;
      end else begin
         state_ff <= state_in;
         if (state_in != state_ff) launch_ff <= 1'b0;
         else if (mul_ctl.start || div_start) launch_ff <= 1'b1;
         if (out_load) rsp_valid_ff <= 1'b1;
         else if (rsp_ready) rsp_valid_ff <= 1'b0;
         if (csr_we) begin
            case (csr_index)
               CSR_GAIN_P:   gain_p_ff   <= csr_wdata;
               CSR_GAIN_I:   gain_i_ff   <= csr_wdata;
               CSR_GAIN_D:   gain_d_ff   <= csr_wdata;
               CSR_MODE:     mode_ff     <= csr_wdata[0];
               CSR_OUT_LOW:  out_low_ff  <= csr_wdata;
               CSR_OUT_HIGH: out_high_ff <= csr_wdata;
               CSR_ACC_LOW:  acc_low_ff  <= csr_wdata;
               CSR_ACC_HIGH: acc_high_ff <= csr_wdata;
               default: ;
            endcase
         end
         if ((state_ff == ST_ERR && (op_ff == OP_CLEAR || !e_fits)) ||
             (state_ff == ST_FIN && fin_fault)) begin
            le_ff    <= '0;
            lle_ff   <= '0;
            acc_ff   <= '0;
            pd_ff    <= '0;
            first_ff <= 1'b1;
         end else if (state_ff == ST_FIN) begin
            acc_ff   <= accf_w[DATA_W-1:0];
            le_ff    <= e_ff;
            first_ff <= 1'b0;
            if (mode_ff == MODE_INC) lle_ff <= le_ff;
            else pd_ff <= deriv_ff;
         end
      end
   end

   // working registers
   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff  <= req_op;
         tgt_ff <= req_target;
         fbk_ff <= req_feedback;
         dt_ff  <= req_step_time;
      end
      case (state_ff)
         ST_ERR: begin
            e_ff     <= e_w[DATA_W-1:0];
            deriv_ff <= '0;
            d_ff     <= '0;
            accn_ff  <= acc_hold_w[DATA_W-1:0];
            res_drive_ff <= '0;
            res_p_ff     <= '0;
            res_i_ff     <= '0;
            res_d_ff     <= '0;
            res_raw_ff   <= '0;
            res_fault_ff <= (op_ff != OP_CLEAR) && !e_fits;
         end
         ST_TRAP: begin
            if (mul_done) begin
               accn_ff <= acc_trap_w[DATA_W-1:0];
            end
         end
         ST_DIV:  if (div_done) deriv_ff <= q_sat;
         ST_FILT: if (mul_done) deriv_ff <= filt_w[DATA_W-1:0];
         ST_MP:   if (mul_done) p_ff <= mul_res;
         ST_MI:   if (mul_done) i_ff <= mul_res;
         ST_MD:   if (mul_done) d_ff <= mul_res;
         ST_SUM: begin
            raw_ff <= rawn_w[34:0];
            flt_ff <= !fits32(p_ff) || !fits32(i_ff) || !fits32(d_ff);
         end
         ST_FIN: begin
            res_fault_ff <= fin_fault;
            if (fin_fault) begin
               res_drive_ff <= '0;
               res_p_ff     <= '0;
               res_i_ff     <= '0;
               res_d_ff     <= '0;
               res_raw_ff   <= '0;
            end else begin
               res_drive_ff <= drv_w[DATA_W-1:0];
               res_p_ff     <= p_ff[DATA_W-1:0];
               res_i_ff     <= i_ff[DATA_W-1:0];
               res_d_ff     <= d_ff[DATA_W-1:0];
               res_raw_ff   <= fits32(raw64) ? raw64[DATA_W-1:0] :
                               (raw64[63] ? S32_MIN : S32_MAX);
            end
         end
         default: ;
      endcase
      if (out_load) begin
         rsp_drive_ff <= res_drive_ff;
         rsp_p_ff     <= res_p_ff;
         rsp_i_ff     <= res_i_ff;
         rsp_d_ff     <= res_d_ff;
         rsp_raw_ff   <= res_raw_ff;
         rsp_fault_ff <= res_fault_ff;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_drive   = rsp_drive_ff;
   assign rsp_p_part  = rsp_p_ff;
   assign rsp_i_part  = rsp_i_ff;
   assign rsp_d_part  = rsp_d_ff;
   assign rsp_raw_sum = rsp_raw_ff;
   assign rsp_fault   = rsp_fault_ff;

   `PIDPI_ASSERT_IMP(a_fault_zero, rsp_valid_ff && rsp_fault_ff, rsp_drive_ff == '0 && rsp_p_ff == '0 && rsp_raw_ff == '0)
   `PIDPI_ASSERT_IMP(a_mul_state, mul_ctl.start, state_ff == ST_TRAP || state_ff == ST_FILT || state_ff == ST_MP || state_ff == ST_MI || state_ff == ST_MD)
   `PIDPI_ASSERT_NXT(a_fault_clears, out_load && res_fault_ff, first_ff && acc_ff == '0)

endmodule

[tb/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PID controller testbench
// Drives control steps and clear requests through the request channel under
// random idling on both sides. Each response is checked field by field against
// a built-in fixed-point model of the positional and incremental loops, typed
// rows against a fixed record. Model state follows the register writes.
// ----------------------------------------------------------------------------
module tb
   import pidpi_pkg::*;
();

   localparam int     FB    = FRAC_BITS_DEF;
   localparam longint I32LO = -64'sd2147483648;
   localparam longint I32HI = 64'sd2147483647;

   typedef struct {
      logic signed [31:0] drive, p_part, i_part, d_part, raw_sum;
      logic               fault;
   } pid_out_type;

   typedef struct {
      int                 cfg_set;
      logic               op;
      logic signed [31:0] target, feedback, step_time;
      bit                 typed;
      pid_out_type        want;
   } stim_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0, req_op = OP_STEP;
   logic req_ready;
   logic signed [31:0] req_target = '0, req_feedback = '0, req_step_time = '0;
   logic rsp_valid, rsp_fault;
   logic rsp_ready = 1'b0;
   logic signed [31:0] rsp_drive, rsp_p_part, rsp_i_part, rsp_d_part, rsp_raw_sum;
   logic csr_we = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [31:0] csr_wdata = '0;

   pid_positional_incremental dut (.*);

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // controller model state and registers
   longint kp, ki, kd, o_lo, o_hi, a_lo, a_hi;
   logic   incr_mode;
   longint last_err, last_err2, integ, last_deriv;
   bit     fresh;

   pid_out_type  pending_q[$];
   stim_row_type rows[$];
   int  mismatches = 0;
   bit  no_stall = 0;

   function automatic logic [127:0] magn(longint a);
      return (a < 0) ? 128'(-a) : 128'(a);
   endfunction

   function automatic longint mulq(longint a, longint b, int sh);
      logic [127:0] m;
      longint r;
      m = (magn(a) * magn(b)) >> sh;
      r = longint'(m[63:0]);
      return ((a < 0) != (b < 0)) ? -r : r;
   endfunction

   function automatic longint clamp(longint v, longint lo, longint hi);
      if (v < lo) return lo;
      if (v > hi) return hi;
      return v;
   endfunction

   function automatic bit fits(longint v);
      return v >= I32LO && v <= I32HI;
   endfunction

   function automatic void clear_loop();
      last_err = 0; last_err2 = 0; integ = 0; last_deriv = 0; fresh = 1;
   endfunction

   function automatic void apply_reg(logic [CSR_IDX_W-1:0] idx, logic [31:0] v);
      longint s;
      s = longint'(signed'(v));
      case (idx)
         CSR_GAIN_P:   kp = s;
         CSR_GAIN_I:   ki = s;
         CSR_GAIN_D:   kd = s;
         CSR_MODE:     incr_mode = v[0];
         CSR_OUT_LOW:  o_lo = s;
         CSR_OUT_HIGH: o_hi = s;
         CSR_ACC_LOW:  a_lo = s;
         CSR_ACC_HIGH: a_hi = s;
         default: ;
      endcase
   endfunction

   function automatic pid_out_type pid_step(logic op, logic signed [31:0] t,
                                            logic signed [31:0] f,
                                            logic signed [31:0] st);
      pid_out_type r;
      longint e, p, i, d, raw, drv, acc, dt, de, deriv, fw;
      logic [127:0] q;
      bit upd;
      r = '{default: '0};
      p = 0; i = 0; d = 0; raw = 0; drv = 0; acc = integ;
      if (op == OP_CLEAR) begin
         clear_loop();
         return r;
      end
      e = longint'(t) - longint'(f);
      if (!fits(e)) begin
         clear_loop();
         r.fault = 1'b1;
         return r;
      end
      dt = longint'(st);
      if (incr_mode == MODE_POS) begin
         deriv = 0;
         upd = !fresh && dt > 0;
         if (upd) acc += mulq(e + last_err, dt, FB + 1);
         acc = clamp(acc, a_lo, a_hi);
         if (upd) begin
            de = e - last_err;
            q = (magn(de) << FB) / 128'(dt);
            deriv = (q > 128'(I32HI)) ? ((de < 0) ? I32LO : I32HI)
                    : ((de < 0) ? -longint'(q[63:0]) : longint'(q[63:0]));
            fw = clamp(D_FILTER_Q16, 0, 65536);
            if (fw > 0) deriv = last_deriv + mulq(65536 - fw, deriv - last_deriv, 16);
         end
         last_deriv = longint'(int'(deriv));
         p = mulq(kp, e, FB);
         i = mulq(ki, acc, FB);
         d = mulq(kd, deriv, FB);
         raw = p + i + d;
         drv = raw;
      end else begin
         if (fresh) begin
            p = mulq(kp, e, FB);
            i = mulq(ki, e, FB);
            raw = p + i;
            drv = raw;
         end else begin
            p = mulq(kp, e - last_err, FB);
            i = mulq(ki, e, FB);
            d = mulq(kd, e - 2 * last_err + last_err2, FB);
            raw = acc + p + i + d;
            drv = clamp(clamp(raw, a_lo, a_hi), o_lo, o_hi);
         end
         acc = drv;
         last_err2 = last_err;
      end
      last_err = e;
      fresh = 0;
      drv = clamp(drv, o_lo, o_hi);
      if (!fits(p) || !fits(i) || !fits(d) || !fits(acc)) begin
         clear_loop();
         r.fault = 1'b1;
         return r;
      end
      integ = acc;
      raw = clamp(raw, I32LO, I32HI);
      r.drive = drv[31:0]; r.p_part = p[31:0]; r.i_part = i[31:0];
      r.d_part = d[31:0]; r.raw_sum = raw[31:0];
      return r;
   endfunction

   // send one request; the transfer happens at the edge where ready is seen
   task automatic send(logic op, logic signed [31:0] t, logic signed [31:0] f,
                       logic signed [31:0] st, bit typed, pid_out_type want);
      pid_out_type got;
      int gap;
      req_valid <= 1'b1; req_op <= op;
      req_target <= t; req_feedback <= f; req_step_time <= st;
      do @(posedge clock); while (!req_ready);
      got = pid_step(op, t, f, st);
      pending_q.push_back(typed ? want : got);
      gap = no_stall ? 0 : $urandom_range(16);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (pending_q.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   // write every register, plus one index past the list
   task automatic write_regs(logic [31:0] v[8]);
      for (int n = 0; n < 9; n++) begin
         logic [31:0] w;
         w = (n < 8) ? v[n] : $urandom;
         csr_we <= 1'b1;
         csr_index <= (n < 8) ? CSR_IDX_W'(n) : CSR_IDX_W'(CSR_ACC_HIGH + n - 7);
         csr_wdata <= w;
         @(posedge clock);
         apply_reg((n < 8) ? CSR_IDX_W'(n) : CSR_IDX_W'(CSR_ACC_HIGH + n - 7), w);
      end
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   function automatic logic [31:0] pick_gain();
      case ($urandom_range(9))
         0:       return 32'h8000_0000;
         1:       return 32'h7fff_ffff;
         2:       return $urandom;
         3:       return '0;
         default: return 32'(int'($urandom_range(0, 1 << 19)) - (1 << 18));
      endcase
   endfunction

   task automatic random_regs();
      logic [31:0] v[8];
      logic [31:0] x, y;
      v[CSR_GAIN_P] = pick_gain();
      v[CSR_GAIN_I] = pick_gain();
      v[CSR_GAIN_D] = pick_gain();
      v[CSR_MODE]   = {31'($urandom), 1'($urandom_range(1))};
      for (int k = 0; k < 2; k++) begin
         x = $urandom; y = $urandom;
         case ($urandom_range(3))
            0: begin x = 32'h8000_0000; y = 32'h7fff_ffff; end
            1: if ($signed(x) > $signed(y)) begin x = x ^ y; y = x ^ y; x = x ^ y; end
            2: begin x = 32'(-($urandom_range(1 << 22))); y = $urandom_range(1 << 22); end
            default: ;
         endcase
         v[CSR_OUT_LOW + 2 * k] = x;
         v[CSR_OUT_HIGH + 2 * k] = y;
      end
      write_regs(v);
   endtask

   function automatic logic signed [31:0] pick_value();
      if ($urandom_range(4) == 0) return $urandom;
      return 32'(int'($urandom_range(0, 1 << 21)) - (1 << 20));
   endfunction

   function automatic logic signed [31:0] pick_time();
      case ($urandom_range(9))
         0:       return '0;
         1:       return -$signed(32'($urandom_range(1, 'h7fff_ffff)));
         2:       return $urandom;
         default: return $urandom_range(1, 1 << 17);
      endcase
   endfunction

   function automatic void add_row(int cs, logic op, logic signed [31:0] t,
                                   logic signed [31:0] f, logic signed [31:0] st,
                                   bit typed, bit flt);
      stim_row_type r;
      r.cfg_set = cs; r.op = op; r.target = t; r.feedback = f; r.step_time = st;
      r.typed = typed;
      r.want = '{default: '0};
      r.want.fault = flt;
      rows.push_back(r);
   endfunction

   task automatic directed_regs(int cs);
      logic [31:0] v[8];
      case (cs)
         1: v = '{32'h0001_0000, 32'h0000_8000, 32'h0000_4000, 32'(MODE_POS),
                  32'hfff0_0000, 32'h0010_0000, 32'hff00_0000, 32'h0100_0000};
         2: v = '{32'h0002_0000, 32'h0000_8000, 32'h0001_0000, 32'(MODE_INC),
                  32'hffe0_0000, 32'h0020_0000, 32'hfff0_0000, 32'h0010_0000};
         default: v = '{32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 32'(MODE_POS),
                        32'h0010_0000, 32'hfff0_0000, 32'h0001_0000, 32'hffff_0000};
      endcase
      write_regs(v);
   endtask

   // response side: random stalls per transfer
   initial begin
      int n;
      @(negedge reset);
      @(posedge clock);
      forever begin
         n = no_stall ? 0 : $urandom_range(16);
         if (n > 0) begin
            rsp_ready <= 1'b0;
            repeat (n) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         pid_out_type w;
         if (pending_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected transfer: drive %0d", rsp_drive);
         end else begin
            w = pending_q.pop_front();
            if (rsp_drive !== w.drive || rsp_p_part !== w.p_part ||
                rsp_i_part !== w.i_part || rsp_d_part !== w.d_part ||
                rsp_raw_sum !== w.raw_sum || rsp_fault !== w.fault) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("exp drv %0d p %0d i %0d d %0d raw %0d f %b / got %0d %0d %0d %0d %0d %b",
                           w.drive, w.p_part, w.i_part, w.d_part, w.raw_sum, w.fault,
                           rsp_drive, rsp_p_part, rsp_i_part, rsp_d_part, rsp_raw_sum,
                           rsp_fault);
            end
         end
      end
   end

   initial begin
      #4ms;
      $display("pid_positional_incremental: mismatch");
      $finish;
   end

   initial begin
      int cs;
      pid_out_type none;
      none = '{default: '0};
      kp = 0; ki = 0; kd = 0; incr_mode = MODE_POS;
      o_lo = I32LO; o_hi = I32HI; a_lo = I32LO; a_hi = I32HI;
      clear_loop();

      add_row(0, OP_STEP, 0, 0, 32'h0001_0000, 1, 0);
      add_row(0, OP_STEP, 32'h7fff_ffff, 32'h8000_0000, 1, 1, 1);
      add_row(0, OP_STEP, 32'h8000_0000, 32'h7fff_ffff, 1, 1, 1);
      add_row(0, OP_STEP, 32'h7fff_ffff, 0, 32'h7fff_ffff, 1, 0);
      add_row(0, OP_STEP, 32'h8000_0000, 0, 32'h8000_0000, 1, 0);
      add_row(0, OP_CLEAR, 32'hffff_ffff, 32'h1234_5678, 32'hffff_ffff, 1, 0);
      add_row(1, OP_STEP, 32'h0003_0000, 32'h0001_0000, 32'h0001_0000, 0, 0);
      add_row(1, OP_STEP, 32'h0004_0000, 32'h0001_0000, 1, 0, 0);
      add_row(1, OP_STEP, 32'h0002_0000, 0, 0, 0, 0);
      add_row(1, OP_STEP, 32'h0001_0000, 0, 32'hffff_0000, 0, 0);
      add_row(1, OP_STEP, 32'h7000_0000, 0, 32'h7fff_ffff, 0, 0);
      add_row(1, OP_STEP, 32'h9000_0000, 0, 32'h0000_1000, 0, 0);
      add_row(1, OP_CLEAR, 0, 0, 0, 1, 0);
      add_row(1, OP_STEP, 32'hffff_0000, 32'h0001_0000, 32'h0000_8000, 0, 0);
      add_row(2, OP_STEP, 32'h0005_0000, 0, 32'h0001_0000, 0, 0);
      add_row(2, OP_STEP, 32'h0002_0000, 32'h0001_0000, 0, 0, 0);
      add_row(2, OP_STEP, 32'hfff0_0000, 0, 32'h0001_0000, 0, 0);
      add_row(2, OP_STEP, 32'h0100_0000, 0, 32'h0001_0000, 0, 0);
      add_row(2, OP_CLEAR, 0, 0, 0, 1, 0);
      add_row(2, OP_STEP, 32'h6000_0000, 32'ha000_0000, 32'h0001_0000, 0, 0);
      add_row(3, OP_STEP, 0, 0, 32'h0001_0000, 0, 0);
      add_row(3, OP_STEP, 32'h0000_0001, 0, 32'h0001_0000, 0, 0);
      add_row(3, OP_STEP, 32'h0100_0000, 0, 32'h0001_0000, 0, 0);

      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      cs = 0;
      foreach (rows[k]) begin
         if (rows[k].cfg_set != cs) begin
            cs = rows[k].cfg_set;
            drain();
            directed_regs(cs);
         end
         send(rows[k].op, rows[k].target, rows[k].feedback, rows[k].step_time,
              rows[k].typed, rows[k].want);
      end

      for (int ph = 0; ph < 13; ph++) begin
         drain();
         no_stall = ($urandom_range(3) == 0);
         random_regs();
         for (int n = 0; n < 100; n++) begin
            if ($urandom_range(19) == 0)
               send(OP_CLEAR, $urandom, $urandom, $urandom, 0, none);
            else
               send(OP_STEP, pick_value(), pick_value(), pick_time(), 0, none);
         end
      end

      req_valid <= 1'b0;
      while (pending_q.size() != 0) @(posedge clock);
      repeat (300) @(posedge clock);
      if (mismatches == 0 && pending_q.size() == 0)
         $display("pid_positional_incremental: match");
      else
         $display("pid_positional_incremental: mismatch");
      $finish;
   end
endmodule
